>>> design/rsla_pkg.sv
// ----------------------------------------------------------------------------
// rsla_pkg
// Shared types and constants for the ring segment link allocator: node id
// width, result select codes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsla_pkg;

    // node ids on the request port
    localparam int NODE_W     = 4;
    localparam int HELD_DEPTH = 2 ** NODE_W;
    localparam int RING_OUT_W = 2;

    typedef logic [NODE_W-1:0] node_t;

    // result select codes
    typedef logic [1:0] res_sel_t;
    localparam res_sel_t RES_IMM    = 2'd0;
    localparam res_sel_t RES_GRANT  = 2'd1;
    localparam res_sel_t RES_REFUSE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     ring_init;
        logic     ring_next;
        logic     wr_alloc;
        logic     wr_release;
        logic     emit;
        res_sel_t res_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic imm;
        logic is_release;
        logic row_ok;
        logic last_ring;
        logic out_free;
    } status_t;

endpackage

>>> design/rsla_ctrl.sv
// ----------------------------------------------------------------------------
// rsla_ctrl
// Request sequencer: captures a request, settles immediate outcomes, then
// walks the rings one row at a time until a path is taken, released or refused.
// ----------------------------------------------------------------------------
module rsla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output rsla_pkg::cmd_t   cmd,
    input  rsla_pkg::status_t status
);
    import rsla_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_CHECK  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RES_IMM;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.imm)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_IMM;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.ring_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.is_release)
                begin
                    if (status.out_free)
                    begin
                        cmd.wr_release = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.res_sel    = RES_GRANT;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.row_ok)
                begin
                    if (status.out_free)
                    begin
                        cmd.wr_alloc = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.res_sel  = RES_GRANT;
                        state_next   = ST_IDLE;
                    end
                end
                else if (status.last_ring)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RES_REFUSE;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.ring_next = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/rsla_dp.sv
// ----------------------------------------------------------------------------
// rsla_dp
// Datapath: request registers, path mask, held-ring table, per-ring segment
// row memory with row valid bits, and the result register.
// ----------------------------------------------------------------------------
module rsla_dp #(
    parameter int NODES = 16,
    parameter int RINGS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              mode,
    input  rsla_pkg::node_t                   source_node,
    input  rsla_pkg::node_t                   dest_node,
    input  rsla_pkg::cmd_t                    cmd,
    output rsla_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              granted,
    output logic [rsla_pkg::RING_OUT_W-1:0]   ring_used,
    output logic                              release_fault
);
    import rsla_pkg::*;

    localparam int RW    = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int ROW_W = NODES * (NODE_W + 1);
    localparam int HALF  = NODES / 2;

    typedef logic [RW-1:0] ring_t;

    // request registers
    logic  req_mode_reg;
    node_t req_src_reg;
    node_t req_dst_reg;
    ring_t ring_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_mode_reg <= mode;
            req_src_reg  <= source_node;
            req_dst_reg  <= dest_node;
        end
    end

    // held-ring table
    logic [HELD_DEPTH-1:0] held_v_reg;
    ring_t                 held_idx_reg [HELD_DEPTH];
    logic                  held_hit;
    ring_t                 held_ring;

    assign held_hit  = held_v_reg[req_src_reg];
    assign held_ring = held_idx_reg[req_src_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg <= '0;
        end
        else if (cmd.wr_alloc)
        begin
            held_v_reg[req_src_reg] <= 1'b1;
        end
        else if (cmd.wr_release)
        begin
            held_v_reg[req_src_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_alloc || cmd.wr_release)
        begin
            held_idx_reg[req_src_reg] <= cmd.wr_alloc ? ring_reg : '0;
        end
    end

    // immediate outcomes
    logic bad_id;
    logic same_node;
    logic imm_granted;
    logic imm_fault;

    assign bad_id      = (32'(req_src_reg) >= NODES) || (32'(req_dst_reg) >= NODES);
    assign same_node   = (req_src_reg == req_dst_reg);
    assign imm_granted = !bad_id && !req_mode_reg && held_hit;
    assign imm_fault   = bad_id ? req_mode_reg : (req_mode_reg && !held_hit);

    // path ends and segment mask
    node_t            lo;
    node_t            hi;
    node_t            from_n;
    node_t            to_n;
    logic             wrap;
    logic [NODES-1:0] path;

    assign lo     = (req_src_reg < req_dst_reg) ? req_src_reg : req_dst_reg;
    assign hi     = (req_src_reg < req_dst_reg) ? req_dst_reg : req_src_reg;
    assign wrap   = (32'(hi - lo) > HALF);
    assign from_n = wrap ? hi : lo;
    assign to_n   = wrap ? lo : hi;

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            if (from_n < to_n)
            begin
                path[i] = (i >= 32'(from_n)) && (i < 32'(to_n));
            end
            else if (from_n > to_n)
            begin
                path[i] = (i >= 32'(from_n)) || (i < 32'(to_n));
            end
            else
            begin
                path[i] = 1'b0;
            end
        end
    end

    // ring counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
        end
        else if (cmd.ring_init)
        begin
            ring_reg <= req_mode_reg ? held_ring : '0;
        end
        else if (cmd.ring_next)
        begin
            ring_reg <= ring_reg + 1'b1;
        end
    end

    // segment row memory, one row per ring
    logic [ROW_W-1:0] seg_mem [RINGS];
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] wr_row;
    logic [RINGS-1:0] rowv_reg;
    logic             seg_wr;

    assign seg_wr = cmd.wr_alloc || cmd.wr_release;

    always_ff @(posedge clk)
    begin
        if (seg_wr)
        begin
            seg_mem[ring_reg] <= wr_row;
        end
        rd_row_reg <= seg_mem[ring_reg];
    end

    // a row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rowv_reg <= '0;
        end
        else if (seg_wr)
        begin
            rowv_reg[ring_reg] <= 1'b1;
        end
    end

    // conflict check and row merge
    logic [NODES-1:0] cur_v;
    logic [NODES-1:0] conflict;
    logic [NODES-1:0] alloc_v;
    logic [NODES-1:0] rel_v;
    logic [NODES-1:0] clr;
    logic [ROW_W-1:0] alloc_row;
    logic [ROW_W-1:0] rel_row;

    assign cur_v = rowv_reg[ring_reg] ? rd_row_reg[NODES-1:0] : '0;

    always_comb
    begin
        alloc_row = rd_row_reg;
        rel_row   = rd_row_reg;
        for (int i = 0; i < NODES; i++)
        begin
            conflict[i] = path[i] && cur_v[i]
                && (rd_row_reg[NODES + NODE_W*i +: NODE_W] != req_src_reg);
            clr[i]      = path[i] && cur_v[i]
                && (rd_row_reg[NODES + NODE_W*i +: NODE_W] == req_src_reg);
            alloc_v[i]  = cur_v[i] || path[i];
            rel_v[i]    = cur_v[i] && !clr[i];
            if (path[i])
            begin
                alloc_row[NODES + NODE_W*i +: NODE_W] = req_src_reg;
            end
            if (clr[i])
            begin
                rel_row[NODES + NODE_W*i +: NODE_W] = '0;
            end
        end
        alloc_row[NODES-1:0] = alloc_v;
        rel_row[NODES-1:0]   = rel_v;
    end

    assign wr_row = cmd.wr_alloc ? alloc_row : rel_row;

    // result register
    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [RING_OUT_W-1:0] ring_used_reg;
    logic                  fault_reg;
    logic                  res_granted;
    ring_t                 res_ring;
    logic                  res_fault;
    logic [RW+1:0]         res_ring_ext;

    always_comb
    begin
        unique case (cmd.res_sel)
            RES_IMM:
            begin
                res_granted = imm_granted;
                res_ring    = imm_granted ? held_ring : '0;
                res_fault   = imm_fault;
            end
            RES_GRANT:
            begin
                res_granted = 1'b1;
                res_ring    = ring_reg;
                res_fault   = 1'b0;
            end
            default:
            begin
                res_granted = 1'b0;
                res_ring    = '0;
                res_fault   = 1'b0;
            end
        endcase
    end

    assign res_ring_ext = {2'b00, res_ring};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            granted_reg   <= res_granted;
            ring_used_reg <= res_ring_ext[RING_OUT_W-1:0];
            fault_reg     <= res_fault;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign ring_used     = ring_used_reg;
    assign release_fault = fault_reg;

    // status to controller
    assign status.imm        = bad_id || (!req_mode_reg && (held_hit || same_node))
                               || (req_mode_reg && !held_hit);
    assign status.is_release = req_mode_reg;
    assign status.row_ok     = ~|conflict;
    assign status.last_ring  = (ring_reg == RW'(RINGS - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

endmodule

>>> design/ring_segment_link_allocator.sv
// ----------------------------------------------------------------------------
// ring_segment_link_allocator
// Reserves or releases a path of ring segments on one of RINGS virtual rings.
// ----------------------------------------------------------------------------
// sequence: immediate outcomes are emitted from the decide state; otherwise
//   each ring tried costs one registered row read plus one check/write of
//   the row memory, and release tries only its held ring. No new request
//   is accepted until the result of the last one has been emitted
// reset: clears the sequencer, the held-ring valid bits, the ring row valid
//   bits and the result valid flag; no clearing pass is needed
module ring_segment_link_allocator #(
    parameter int NODES = 16,
    parameter int RINGS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  rsla_pkg::node_t                   source_node,
    input  rsla_pkg::node_t                   dest_node,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              granted,
    output logic [rsla_pkg::RING_OUT_W-1:0]   ring_used,
    output logic                              release_fault
);
    import rsla_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    rsla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // segment and held-ring storage
    rsla_dp #(
        .NODES (NODES),
        .RINGS (RINGS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .source_node   (source_node),
        .dest_node     (dest_node),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .ring_used     (ring_used),
        .release_fault (release_fault)
    );

    // an accepted beat blocks the input until its result is emitted
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous request in flight");

    // row writes only with a result beat
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_alloc || cmd.wr_release) |-> cmd.emit)
        else $error("segment row written without result");

    // never overwrite an untaken result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result register overwritten");

    // allocate and release writes are exclusive
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_alloc && cmd.wr_release))
        else $error("conflicting row writes");

endmodule

>>> dv/ring_segment_link_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_segment_link_allocator_tb
// Drives allocate and release requests into the ring segment link allocator
// and holds its own copy of the segment owners and the held rings, so that
// every result beat is compared field by field with the predicted outcome.
// Directed cases cover refusals, release faults, path wraparound, paths that
// start and end on the same node, segments owned by other nodes and full
// rings. Random path traffic and random noise follow, with idles on both sides.
// ----------------------------------------------------------------------------
module ring_segment_link_allocator_tb;

    import rsla_pkg::*;

    localparam int NODES      = 16;
    localparam int RINGS      = 4;
    localparam int IDLE_PCT   = 22;
    localparam int HANG_LIMIT = 2000;
    localparam int DRAIN_WAIT = 20;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic       granted;
        logic [1:0] ring;
        logic       fault;
    } outcome_t;

    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  in_valid      = 1'b0;
    logic  mode          = MODE_ALLOC;
    node_t source_node   = '0;
    node_t dest_node     = '0;
    logic  out_stall     = 1'b0;
    logic  in_stall;
    logic  out_valid;
    logic  granted;
    logic [RING_OUT_W-1:0] ring_used;
    logic  release_fault;

    // allocator state as the testbench expects it
    bit    seg_busy [RINGS][NODES];
    node_t seg_owner [RINGS][NODES];
    bit    held_valid [NODES];
    int    held_ring [NODES];

    // far end of the path each node last asked for, used for clean releases
    node_t path_dest [NODES];

    outcome_t pending_outcomes[$];
    int       mismatch_count = 0;
    int       stuck_cycles   = 0;
    bit       calm           = 1'b0;

    ring_segment_link_allocator #(
        .NODES(NODES),
        .RINGS(RINGS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .source_node(source_node),
        .dest_node(dest_node),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .granted(granted),
        .ring_used(ring_used),
        .release_fault(release_fault)
    );

    always #5 clk = ~clk;

    // receiver stalls at random outside calm stretches
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // path runs up from the lower id, or from the higher id with wraparound
    function automatic void path_bounds(input node_t a, input node_t b,
                                        output int from, output int to);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi - lo > NODES / 2)
        begin
            from = hi;
            to   = lo;
        end
        else
        begin
            from = lo;
            to   = hi;
        end
    endfunction

    // outcome of one request, updating the expected allocator state
    function automatic outcome_t predict_request(logic m, node_t s, node_t d);
        outcome_t res;
        int       from;
        int       to;
        int       seg;
        int       r;
        bit       fits;
        res = '0;
        if (s >= NODES || d >= NODES)
        begin
            res.fault = (m == MODE_RELEASE);
        end
        else if (m == MODE_ALLOC)
        begin
            if (held_valid[s])
            begin
                res.granted = 1'b1;
                res.ring    = held_ring[s][1:0];
            end
            else if (s != d)
            begin
                path_bounds(s, d, from, to);
                for (r = 0; r < RINGS && !res.granted; r++)
                begin
                    fits = 1'b1;
                    for (seg = from; seg != to; seg = (seg + 1) % NODES)
                    begin
                        if (seg_busy[r][seg] && seg_owner[r][seg] != s)
                        begin
                            fits = 1'b0;
                            break;
                        end
                    end
                    if (fits)
                    begin
                        for (seg = from; seg != to; seg = (seg + 1) % NODES)
                        begin
                            seg_busy[r][seg]  = 1'b1;
                            seg_owner[r][seg] = s;
                        end
                        held_valid[s] = 1'b1;
                        held_ring[s]  = r;
                        res.granted   = 1'b1;
                        res.ring      = r[1:0];
                    end
                end
            end
        end
        else if (!held_valid[s])
        begin
            res.fault = 1'b1;
        end
        else
        begin
            // only segments still owned by the source are freed
            r = held_ring[s] % RINGS;
            path_bounds(s, d, from, to);
            for (seg = from; seg != to; seg = (seg + 1) % NODES)
            begin
                if (seg_busy[r][seg] && seg_owner[r][seg] == s)
                    seg_busy[r][seg] = 1'b0;
            end
            held_valid[s] = 1'b0;
            held_ring[s]  = 0;
            res.granted   = 1'b1;
            res.ring      = r[1:0];
        end
        return res;
    endfunction

    // send one request beat and record its expected outcome on accept
    task automatic send_request(input logic m, input node_t s, input node_t d);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        mode        <= m;
        source_node <= s;
        dest_node   <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (m == MODE_ALLOC && !held_valid[s])
            path_dest[s] = d;
        pending_outcomes.insert(pending_outcomes.size(), predict_request(m, s, d));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // compare each result beat with the oldest expected outcome
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result beat with no request pending, granted", granted, 0);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (granted !== want.granted)
                    report_mismatch("granted", granted, want.granted);
                if (ring_used !== want.ring)
                    report_mismatch("ring_used", ring_used, want.ring);
                if (release_fault !== want.fault)
                    report_mismatch("release_fault", release_fault, want.fault);
            end
        end
    end

    // end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == HANG_LIMIT)
            begin
                $display("ring_segment_link_allocator verification failed");
                $finish;
            end
        end
    end

    // release with nothing held, and a path from a node to itself
    task automatic test_refusals_and_faults();
        send_request(MODE_RELEASE, 0, 0);
        send_request(MODE_RELEASE, 15, 3);
        send_request(MODE_ALLOC, 5, 5);
    endtask

    // wraparound path, repeat grant, and paths exactly half the ring long
    task automatic test_path_extremes();
        send_request(MODE_ALLOC, 0, 15);
        send_request(MODE_ALLOC, 0, 15);
        send_request(MODE_RELEASE, 0, 15);
        send_request(MODE_ALLOC, 7, 15);
        send_request(MODE_ALLOC, 8, 0);
        send_request(MODE_RELEASE, 7, 15);
        send_request(MODE_RELEASE, 8, 0);
    endtask

    // a held node asking for an empty path, and releasing it twice
    task automatic test_same_node_paths();
        send_request(MODE_ALLOC, 3, 4);
        send_request(MODE_ALLOC, 3, 3);
        send_request(MODE_RELEASE, 3, 3);
        send_request(MODE_RELEASE, 3, 3);
    endtask

    // release over segments another node owns leaves them in place
    task automatic test_foreign_segments();
        send_request(MODE_ALLOC, 0, 4);
        send_request(MODE_ALLOC, 4, 8);
        send_request(MODE_RELEASE, 0, 8);
        send_request(MODE_ALLOC, 1, 5);
    endtask

    // four overlapping paths fill every ring, the fifth is refused
    task automatic test_ring_exhaustion();
        send_request(MODE_ALLOC, 9, 13);
        send_request(MODE_ALLOC, 10, 14);
        send_request(MODE_ALLOC, 11, 15);
        send_request(MODE_ALLOC, 12, 0);
        send_request(MODE_ALLOC, 13, 12);
    endtask

    // mostly allocate and matching release pairs with random paths
    task automatic test_random_paths(input int count);
        node_t s;
        node_t d;
        int    pick;
        for (int i = 0; i < count; i++)
        begin
            calm = (i < count / 4);
            s    = node_t'($urandom_range(NODES - 1));
            pick = $urandom_range(99);
            if (held_valid[s])
            begin
                if (pick < 75)
                    send_request(MODE_RELEASE, s, path_dest[s]);
                else if (pick < 85)
                    send_request(MODE_ALLOC, s, node_t'($urandom_range(NODES - 1)));
                else
                    send_request(MODE_RELEASE, s, node_t'($urandom_range(NODES - 1)));
            end
            else if (pick < 85)
            begin
                // short paths most of the time so many nodes hold at once
                if ($urandom_range(3) == 0)
                    d = node_t'((s + $urandom_range(NODES - 1, 1)) % NODES);
                else
                    d = node_t'((s + $urandom_range(3, 1)) % NODES);
                send_request(MODE_ALLOC, s, d);
            end
            else if (pick < 92)
            begin
                send_request(MODE_ALLOC, s, s);
            end
            else
            begin
                send_request(MODE_RELEASE, s, node_t'($urandom_range(NODES - 1)));
            end
        end
        calm = 1'b0;
    endtask

    // fully random request beats
    task automatic test_random_noise(input int count);
        for (int i = 0; i < count; i++)
            send_request(1'($urandom_range(1)), node_t'($urandom_range(NODES - 1)),
                         node_t'($urandom_range(NODES - 1)));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_refusals_and_faults();
        test_path_extremes();
        test_same_node_paths();
        test_foreign_segments();
        test_ring_exhaustion();
        test_random_paths(1000);
        test_random_noise(200);

        // drain outstanding results, then give the block time to settle
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("ring_segment_link_allocator verification clean");
        else
            $display("ring_segment_link_allocator verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/rsla_pkg.sv
design/rsla_ctrl.sv
design/rsla_dp.sv
design/ring_segment_link_allocator.sv
dv/ring_segment_link_allocator_tb.sv
